/* hdl/ihc_pkg.sv */
// shared types, constants and helpers for the ipv4 receive header checker
// no dependencies
package ihc_pkg;

  localparam int HEADER_WORDS = 10;
  localparam logic [15:0] HEADER_BYTES = 16'(HEADER_WORDS * 2);
  localparam logic [3:0] WORD_LAST = 4'(HEADER_WORDS - 1);

  localparam logic [3:0] WORD_TOTAL_LEN = 4'd1;
  localparam logic [3:0] WORD_PROTO = 4'd4;
  localparam logic [3:0] WORD_SRC_HI = 4'd6;
  localparam logic [3:0] WORD_SRC_LO = 4'd7;
  localparam logic [3:0] WORD_DST_HI = 4'd8;

  localparam logic [31:0] LIMITED_BROADCAST = 32'hFFFF_FFFF;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_TOO_SHORT = 2'd1;
  localparam logic [1:0] VERDICT_NOT_HERE = 2'd2;
  localparam logic [1:0] VERDICT_BAD_SUM = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] CLASS_ICMP = 2'd0;
  localparam logic [1:0] CLASS_TCP = 2'd1;
  localparam logic [1:0] CLASS_UDP = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  localparam logic REG_OWN_ADDR = 1'b0;
  localparam logic REG_OWN_BROADCAST = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        too_short;
    logic [15:0] sum;
    logic [15:0] frame_len;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } ihc_job_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

/* hdl/ihc_front.sv */
// header word parser: sums and captures header fields, emits one job per frame
// depends on ihc_pkg
module ihc_front
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] header_word,
  input  logic        first_word,
  input  logic [15:0] frame_length,
  output logic        job_valid,
  output ihc_job_t    job
);

  logic [3:0]  word_count;
  logic [15:0] sum_acc;
  logic [15:0] sum_next;
  logic [15:0] frame_len_held;
  logic [15:0] total_len_held;
  logic [7:0]  proto_held;
  logic [31:0] src_held;
  logic [15:0] dst_hi_held;
  logic        short_frame;

  assign short_frame = frame_length < HEADER_BYTES;
  assign sum_next = ones_add(sum_acc, header_word);

  always_comb begin
    job.too_short = first_word;
    job.sum = sum_next;
    job.frame_len = frame_len_held;
    job.total_len = total_len_held;
    job.proto = proto_held;
    job.src = src_held;
    job.dst = {dst_hi_held, header_word};
    if (first_word) begin
      job_valid = accept && short_frame;
    end else begin
      job_valid = accept && (word_count == WORD_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (accept) begin
      if (first_word) begin
        word_count <= short_frame ? 4'd0 : 4'd1;
      end else if (word_count != 4'd0) begin
        word_count <= (word_count == WORD_LAST) ? 4'd0 : word_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (first_word) begin
        frame_len_held <= frame_length;
        sum_acc <= header_word;
      end else if (word_count != 4'd0) begin
        sum_acc <= sum_next;
        case (word_count)
          WORD_TOTAL_LEN: total_len_held <= header_word;
          WORD_PROTO:     proto_held <= header_word[7:0];
          WORD_SRC_HI:    src_held[31:16] <= header_word;
          WORD_SRC_LO:    src_held[15:0] <= header_word;
          WORD_DST_HI:    dst_hi_held <= header_word;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) word_count <= WORD_LAST)
    else $error("word count past last header word");

endmodule

/* hdl/ihc_queue.sv */
// short job queue between header parser and verdict stage
// depends on ihc_pkg
module ihc_queue
  import ihc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ihc_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output ihc_job_t head_job
);

  ihc_job_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("job queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("job queue underflow");

endmodule

/* hdl/ihc_back.sv */
// verdict stage: address and checksum checks, class, payload length, result register
// depends on ihc_pkg
module ihc_back
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  ihc_job_t    job,
  output logic        take,
  input  logic [31:0] own_addr,
  input  logic [31:0] own_broadcast,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [7:0]  protocol_number,
  output logic [31:0] source_addr,
  output logic [31:0] dest_addr,
  output logic [15:0] payload_length
);

  logic        out_valid;
  logic        dst_match;
  logic [15:0] len_min;
  logic [15:0] pay_len;
  logic [1:0]  verdict_next;
  logic [1:0]  class_next;

  assign take = job_valid && (!out_valid || pop);
  assign empty = !out_valid;

  assign dst_match = (job.dst == own_addr) || (job.dst == own_broadcast) ||
                     (job.dst == LIMITED_BROADCAST);
  assign len_min = (job.total_len < job.frame_len) ? job.total_len : job.frame_len;
  assign pay_len = (len_min > HEADER_BYTES) ? len_min - HEADER_BYTES : 16'd0;

  always_comb begin
    if (job.too_short) begin
      verdict_next = VERDICT_TOO_SHORT;
    end else if (!dst_match) begin
      verdict_next = VERDICT_NOT_HERE;
    end else if (job.sum != SUM_GOOD) begin
      verdict_next = VERDICT_BAD_SUM;
    end else begin
      verdict_next = VERDICT_ACCEPT;
    end
    case (job.proto)
      PROTO_ICMP: class_next = CLASS_ICMP;
      PROTO_TCP:  class_next = CLASS_TCP;
      PROTO_UDP:  class_next = CLASS_UDP;
      default:    class_next = CLASS_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      verdict <= verdict_next;
      if (job.too_short) begin
        protocol_class <= '0;
        protocol_number <= '0;
        source_addr <= '0;
        dest_addr <= '0;
        payload_length <= '0;
      end else begin
        protocol_class <= class_next;
        protocol_number <= job.proto;
        source_addr <= job.src;
        dest_addr <= job.dst;
        payload_length <= pay_len;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) take |=> out_valid)
    else $error("result register lost a loaded request");

endmodule

/* hdl/ipv4_rx_header_check.sv */
// ipv4 receive header checker top: config registers, parser, job queue, verdict stage
// a frame's job is written into the job queue on the edge that accepts its last word, and the verdict
// stage loads it from the queue head into the result register once that register is free
// throughput: one header word per cycle while full is low; full rises only when the four-entry job queue is full
// reset: synchronous active high; clears control state, own_addr to 0, own_broadcast to all ones
// depends on ihc_pkg, ihc_front, ihc_queue, ihc_back
module ipv4_rx_header_check
  import ihc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] header_word,
  input  logic        first_word,
  input  logic [15:0] frame_length,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  verdict,
  output logic [1:0]  protocol_class,
  output logic [7:0]  protocol_number,
  output logic [31:0] source_addr,
  output logic [31:0] dest_addr,
  output logic [15:0] payload_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] own_addr;
  logic [31:0] own_broadcast;
  logic        accept;
  logic        job_valid;
  ihc_job_t    job;
  logic        q_full;
  logic        q_not_empty;
  ihc_job_t    head_job;
  logic        take;

  assign cfg_ready = 1'b1;
  assign full = q_full;
  assign accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_addr <= '0;
      own_broadcast <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDR:      own_addr <= cfg_data;
        REG_OWN_BROADCAST: own_broadcast <= cfg_data;
        default: ;
      endcase
    end
  end

  ihc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .header_word  (header_word),
    .first_word   (first_word),
    .frame_length (frame_length),
    .job_valid    (job_valid),
    .job          (job)
  );

  ihc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_job  (job),
    .pop       (take),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  ihc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (q_not_empty),
    .job             (head_job),
    .take            (take),
    .own_addr        (own_addr),
    .own_broadcast   (own_broadcast),
    .pop             (pop),
    .empty           (empty),
    .verdict         (verdict),
    .protocol_class  (protocol_class),
    .protocol_number (protocol_number),
    .source_addr     (source_addr),
    .dest_addr       (dest_addr),
    .payload_length  (payload_length)
  );

endmodule
